### rtl/op_run_merge_peephole_top_defines.svh
// ----------------------------------------------------------------------------
// op_run_merge_peephole_top_defines.svh
// Assertion macros shared by the peephole RTL.
// ----------------------------------------------------------------------------
`ifndef OP_RUN_MERGE_PEEPHOLE_TOP_DEFINES_SVH
`define OP_RUN_MERGE_PEEPHOLE_TOP_DEFINES_SVH

// Same-cycle implication on clk, quiet during reset
`define ORM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, quiet during reset
`define ORM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/orm_pkg.sv
// ----------------------------------------------------------------------------
// orm_pkg
// Codes, widths and shared types of the run-merge peephole.
// ----------------------------------------------------------------------------
package orm_pkg;

	localparam int VALUE_BITS  = 16;
	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);

	// input operation codes
	localparam logic [2:0] OP_INC  = 3'd0;
	localparam logic [2:0] OP_DEC  = 3'd1;
	localparam logic [2:0] OP_FWD  = 3'd2;
	localparam logic [2:0] OP_BACK = 3'd3;
	localparam logic [2:0] OP_JZ   = 3'd4;
	localparam logic [2:0] OP_JNZ  = 3'd5;

	// result codes
	localparam logic [3:0] RES_DEC = 4'd1;
	localparam logic [3:0] RES_JZ  = 4'd4;
	localparam logic [3:0] RES_SZ  = 4'd8;

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic [2:0] run_code;
		value_t     run_sum;
		logic       run_open;
		logic       jz_held;
		logic       dec_held;
		value_t     held_dec_value;
	} orm_state_t;

	typedef struct packed {
		logic [3:0] code;
		value_t     value;
		logic       last;
	} orm_result_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] cnt;
		logic                room;
	} orm_qstat_t;

endpackage

### rtl/orm_step.sv
// ----------------------------------------------------------------------------
// orm_step
// Peephole update for one item: next held state and up to three results.
// ----------------------------------------------------------------------------
module orm_step import orm_pkg::*; (
	input  orm_state_t             st,
	input  logic [2:0]             code,
	input  value_t                 value,
	input  logic                   last,
	output orm_state_t             st_nxt,
	output orm_result_t            res [MAX_RESULTS],
	output logic [NRES_BITS-1:0]   res_n
);

	logic do_take;

	always_comb begin
		st_nxt  = st;
		do_take = 1'b0;
		res_n   = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '0;
		end

		// clear-loop pattern tracking
		if (st.jz_held && st.dec_held) begin
			st_nxt.jz_held  = 1'b0;
			st_nxt.dec_held = 1'b0;
			if (code == OP_JNZ) begin
				res[res_n] = '{code: RES_SZ, value: '0, last: 1'b0};
				res_n = res_n + 1'b1;
			end else if (code == OP_DEC) begin
				res[res_n] = '{code: RES_JZ, value: '0, last: 1'b0};
				res_n = res_n + 1'b1;
				st_nxt.run_open = 1'b1;
				st_nxt.run_code = OP_DEC;
				st_nxt.run_sum  = st.held_dec_value + value;
			end else begin
				res[res_n] = '{code: RES_JZ, value: '0, last: 1'b0};
				res_n = res_n + 1'b1;
				res[res_n] = '{code: RES_DEC, value: st.held_dec_value, last: 1'b0};
				res_n = res_n + 1'b1;
				do_take = 1'b1;
			end
			st_nxt.held_dec_value = '0;
		end else if (st.jz_held) begin
			if (code == OP_DEC) begin
				st_nxt.dec_held       = 1'b1;
				st_nxt.held_dec_value = value;
			end else begin
				st_nxt.jz_held = 1'b0;
				res[res_n] = '{code: RES_JZ, value: '0, last: 1'b0};
				res_n = res_n + 1'b1;
				do_take = 1'b1;
			end
		end else begin
			do_take = 1'b1;
		end

		// normal handling: run merge, jz hold, pass-through
		if (do_take) begin
			if (code <= OP_BACK) begin
				if (st_nxt.run_open && st_nxt.run_code == code) begin
					st_nxt.run_sum = st_nxt.run_sum + value;
				end else begin
					if (st_nxt.run_open) begin
						res[res_n] = '{code: {1'b0, st_nxt.run_code}, value: st_nxt.run_sum,
							last: 1'b0};
						res_n = res_n + 1'b1;
					end
					st_nxt.run_open = 1'b1;
					st_nxt.run_code = code;
					st_nxt.run_sum  = value;
				end
			end else begin
				if (st_nxt.run_open) begin
					res[res_n] = '{code: {1'b0, st_nxt.run_code}, value: st_nxt.run_sum,
						last: 1'b0};
					res_n = res_n + 1'b1;
					st_nxt.run_open = 1'b0;
				end
				if (code == OP_JZ) begin
					st_nxt.jz_held = 1'b1;
				end else begin
					res[res_n] = '{code: {1'b0, code}, value: value, last: 1'b0};
					res_n = res_n + 1'b1;
				end
			end
		end

		// end of program: flush everything held
		if (last) begin
			if (st_nxt.run_open) begin
				res[res_n] = '{code: {1'b0, st_nxt.run_code}, value: st_nxt.run_sum,
					last: 1'b0};
				res_n = res_n + 1'b1;
			end
			if (st_nxt.jz_held) begin
				res[res_n] = '{code: RES_JZ, value: '0, last: 1'b0};
				res_n = res_n + 1'b1;
			end
			if (st_nxt.dec_held) begin
				res[res_n] = '{code: RES_DEC, value: st_nxt.held_dec_value, last: 1'b0};
				res_n = res_n + 1'b1;
			end
			st_nxt = '0;
			if (res_n != '0) begin
				res[res_n - 1'b1].last = 1'b1;
			end
		end
	end

endmodule

### rtl/orm_queue.sv
// ----------------------------------------------------------------------------
// orm_queue
// Shifting result buffer: head at slot 0, up to three pushes per cycle.
// ----------------------------------------------------------------------------
module orm_queue import orm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  orm_result_t          push_data [MAX_RESULTS],
	input  logic [NRES_BITS-1:0] push_n,
	input  logic                 pop,
	output orm_result_t          head,
	output orm_qstat_t           stat
);

	orm_result_t          slot_q [QUEUE_DEPTH];
	orm_result_t          slot_d [QUEUE_DEPTH];
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CNT_BITS-1:0]  cnt_d;
	logic [CNT_BITS-1:0]  base;
	logic [CNT_BITS-1:0]  wr_idx;

	// shift on pop, then append the new results behind the survivors
	always_comb begin
		base = cnt_q - {{(CNT_BITS-1){1'b0}}, pop};
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			slot_d[i] = pop ? slot_q[i+1] : slot_q[i];
		end
		slot_d[QUEUE_DEPTH-1] = slot_q[QUEUE_DEPTH-1];
		wr_idx = base;
		for (int j = 0; j < MAX_RESULTS; j++) begin
			if (push_n > NRES_BITS'(j)) begin
				slot_d[wr_idx[SLOT_BITS-1:0]] = push_data[j];
			end
			wr_idx = wr_idx + 1'b1;
		end
		cnt_d = base + CNT_BITS'(push_n);
	end

	// payload slots
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	assign head      = slot_q[0];
	assign stat.cnt  = cnt_q;
	assign stat.room = (cnt_q <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));

endmodule

### rtl/op_run_merge_peephole_top.sv
// ----------------------------------------------------------------------------
// op_run_merge_peephole_top
// Run-length merge and clear-loop peephole over an operation stream.
//
// Input channel (in_valid/in_ready) carries one operation per item: op_code,
// op_value and end_of_program. Output channel (out_valid/out_ready) carries
// one result per item: out_code, out_value, out_last.
// Runs of inc/dec/fwd/back merge into one result (sum wraps at 16 bits);
// jz, dec, jnz becomes one set-zero result; jz leaves with value 0.
// end_of_program flushes all held work and marks the last result out_last.
// out_valid for the first result of an item rises once the item has passed
// the input stage register and been written into the result buffer.
// Throughput: one item per cycle while each item causes at most one result
// and out_ready stays high; the single output port delivers one result per
// cycle, so an item causing several results holds the port for each of them.
// The input stage advances only when the 4-entry result buffer has room for
// three results, so an output stall backs up into in_ready.
// Reset empties the input stage, the result buffer and all held runs.
// ----------------------------------------------------------------------------
`include "op_run_merge_peephole_top_defines.svh"

module op_run_merge_peephole_top import orm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   op_code,
	input  logic [15:0]  op_value,
	input  logic         end_of_program,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [3:0]   out_code,
	output logic [15:0]  out_value,
	output logic         out_last
);

	logic                 v_s1;
	logic [2:0]           code_s1;
	value_t               value_s1;
	logic                 last_s1;
	logic                 step_go;
	orm_state_t           st_q;
	orm_state_t           st_nxt;
	orm_result_t          res [MAX_RESULTS];
	logic [NRES_BITS-1:0] res_n;
	logic [NRES_BITS-1:0] push_n;
	orm_result_t          head;
	orm_qstat_t           q_stat;
	logic                 pop;

	// input stage handshake
	assign step_go  = v_s1 && q_stat.room;
	assign in_ready = !v_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1  <= op_code;
			value_s1 <= op_value;
			last_s1  <= end_of_program;
		end
	end

	// peephole update
	orm_step u_step (
		.st     (st_q),
		.code   (code_s1),
		.value  (value_s1),
		.last   (last_s1),
		.st_nxt (st_nxt),
		.res    (res),
		.res_n  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_go) begin
			st_q <= st_nxt;
		end
	end

	// result buffer and output port
	assign push_n = step_go ? res_n : '0;
	assign pop    = out_valid && out_ready;

	orm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (res),
		.push_n    (push_n),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	assign out_valid = (q_stat.cnt != '0);
	assign out_code  = head.code;
	assign out_value = head.value;
	assign out_last  = head.last;

	// checks
	`ORM_ASSERT_NEXT(a_no_overflow, step_go, q_stat.cnt <= CNT_BITS'(QUEUE_DEPTH), "result buffer overflow")
	`ORM_ASSERT_NOW(a_last_has_result, step_go && last_s1, res_n != '0, "end of program gave no result")
	`ORM_ASSERT_NEXT(a_last_clears, step_go && last_s1, st_q == '0, "held state not cleared after end of program")
	`ORM_ASSERT_NOW(a_run_jz_excl, 1'b1, !(st_q.run_open && st_q.jz_held), "run open while jz held")
	`ORM_ASSERT_NOW(a_dec_needs_jz, st_q.dec_held, st_q.jz_held, "held decrement without held jz")

endmodule

### tb/tb_op_run_merge_peephole_top.sv
// ----------------------------------------------------------------------------
// tb_op_run_merge_peephole_top
// Self-checking testbench for the run-merge and clear-loop peephole.
//
// A scoreboard class predicts the result items of every accepted operation.
// It merges runs, folds jz/dec/jnz into set-zero and flushes on
// end_of_program. Each result item leaving the block is checked against the
// oldest prediction. A directed sequence covers the edge cases. It is
// followed by random programs built mostly from runs and clear loops, with
// broken patterns and noise mixed in. The sender works in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_op_run_merge_peephole_top;
	import orm_pkg::*;

	// codes 6 and 7 pass through untouched
	localparam logic [2:0] OP_OTHER_A = 3'd6;
	localparam logic [2:0] OP_OTHER_B = 3'd7;

	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 335;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 200000;

	// Predicts result items from accepted operations and checks the block
	class peephole_scoreboard;
		orm_result_t exp_q[$];
		int          errors;
		logic [2:0]  run_code;
		value_t      run_sum;
		logic        run_open;
		logic        jz_held;
		logic        dec_held;
		value_t      held_dec;
		int          n_step;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			run_code = '0;
			run_sum  = '0;
			run_open = 1'b0;
			jz_held  = 1'b0;
			dec_held = 1'b0;
			held_dec = '0;
		endfunction

		// one expected result item; at most MAX_RESULTS per operation
		function void push(logic [3:0] c, value_t v);
			orm_result_t r;
			if (n_step < MAX_RESULTS) begin
				r.code  = c;
				r.value = v;
				r.last  = 1'b0;
				exp_q.push_back(r);
				n_step++;
			end
		endfunction

		// normal handling: extend/close runs, hold jz, pass the rest
		function void take(logic [2:0] c, value_t v);
			if (c <= OP_BACK) begin
				if (run_open && run_code == c) begin
					run_sum = run_sum + v;
				end else begin
					if (run_open)
						push({1'b0, run_code}, run_sum);
					run_open = 1'b1;
					run_code = c;
					run_sum  = v;
				end
			end else begin
				if (run_open) begin
					push({1'b0, run_code}, run_sum);
					run_open = 1'b0;
				end
				if (c == OP_JZ)
					jz_held = 1'b1;
				else
					push({1'b0, c}, v);
			end
		endfunction

		function void note_op(logic [2:0] c, value_t v, logic l);
			orm_result_t r;
			n_step = 0;
			if (jz_held && dec_held) begin
				jz_held  = 1'b0;
				dec_held = 1'b0;
				if (c == OP_JNZ) begin
					push(RES_SZ, '0);
				end else if (c == OP_DEC) begin
					// second dec breaks the loop and opens a dec run
					push(RES_JZ, '0);
					run_open = 1'b1;
					run_code = OP_DEC;
					run_sum  = held_dec + v;
				end else begin
					push(RES_JZ, '0);
					push(RES_DEC, held_dec);
					take(c, v);
				end
				held_dec = '0;
			end else if (jz_held) begin
				if (c == OP_DEC) begin
					dec_held = 1'b1;
					held_dec = v;
				end else begin
					jz_held = 1'b0;
					push(RES_JZ, '0);
					take(c, v);
				end
			end else begin
				take(c, v);
			end

			// end of program: flush everything held, mark the final item
			if (l) begin
				if (run_open)
					push({1'b0, run_code}, run_sum);
				if (jz_held)
					push(RES_JZ, '0);
				if (dec_held)
					push(RES_DEC, held_dec);
				clear();
				if (n_step > 0) begin
					r = exp_q.pop_back();
					r.last = 1'b1;
					exp_q.push_back(r);
				end
			end
		endfunction

		function void check_result(logic [3:0] c, value_t v, logic l);
			orm_result_t r;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected result item code %0d value %h last %b",
					$time, c, v, l);
				errors++;
			end else begin
				r = exp_q.pop_front();
				if (c !== r.code) begin
					$display("%0t: out_code expected %0d actual %0d", $time, r.code, c);
					errors++;
				end
				if (v !== r.value) begin
					$display("%0t: out_value expected %h actual %h", $time, r.value, v);
					errors++;
				end
				if (l !== r.last) begin
					$display("%0t: out_last expected %b actual %b", $time, r.last, l);
					errors++;
				end
			end
		endfunction

		function int pending();
			return exp_q.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [2:0]   op_code = '0;
	logic [15:0]  op_value = '0;
	logic         end_of_program = 1'b0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [3:0]   out_code;
	logic [15:0]  out_value;
	logic         out_last;

	peephole_scoreboard sb = new();
	int items_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	op_run_merge_peephole_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op_code        (op_code),
		.op_value       (op_value),
		.end_of_program (end_of_program),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_code       (out_code),
		.out_value      (out_value),
		.out_last       (out_last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: check accepted items, stall in changing patterns
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_code, out_value, out_last);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_phase % 4 == 0);
			default: out_ready <= (stall_phase % 16 == 15);
		endcase
	end

	// present one item and hold it until accepted
	task automatic send_op(input logic [2:0] c, input logic [15:0] v, input logic l);
		in_valid       <= 1'b1;
		op_code        <= c;
		op_value       <= v;
		end_of_program <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_op(c, v, l);
		items_sent++;
	endtask

	// send in bursts with random gaps between them
	task automatic issue(input logic [2:0] c, input logic [15:0] v, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		send_op(c, v, l);
		burst_left--;
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic rand_last();
		return ($urandom_range(0, 15) == 0);
	endfunction

	task automatic directed_ops();
		issue(OP_INC, 16'hFFFF, 1'b0);
		issue(OP_INC, 16'h0001, 1'b0);     // sum wraps to zero
		issue(OP_DEC, 16'h1234, 1'b0);
		issue(OP_FWD, 16'h0000, 1'b0);
		issue(OP_BACK, 16'hFFFF, 1'b0);
		// clear loop; jz value ignored
		issue(OP_JZ, 16'hABCD, 1'b0);
		issue(OP_DEC, 16'h0001, 1'b0);
		issue(OP_JNZ, 16'h5555, 1'b0);
		// second dec breaks the pattern
		issue(OP_JZ, 16'h0000, 1'b0);
		issue(OP_DEC, 16'h0007, 1'b0);
		issue(OP_DEC, 16'h0008, 1'b0);
		// broken after the held dec
		issue(OP_JZ, 16'h0001, 1'b0);
		issue(OP_DEC, 16'h0003, 1'b0);
		issue(OP_FWD, 16'h0002, 1'b0);
		// broken right after jz
		issue(OP_JZ, 16'h0000, 1'b0);
		issue(OP_INC, 16'h0009, 1'b0);
		issue(OP_JNZ, 16'hFFFF, 1'b0);
		issue(OP_OTHER_A, 16'h8000, 1'b0);
		issue(OP_OTHER_B, 16'h00FF, 1'b1);
		// end of program on held jz, and on jz plus dec
		issue(OP_JZ, 16'h0000, 1'b1);
		issue(OP_JZ, 16'h0000, 1'b0);
		issue(OP_DEC, 16'h0005, 1'b1);
		issue(OP_INC, 16'h0003, 1'b1);
		issue(OP_JZ, 16'h0000, 1'b0);
		issue(OP_JZ, 16'hFFFF, 1'b1);
	endtask

	// random programs: mostly runs and clear loops, some broken, some noise
	task automatic random_ops();
		int kind;
		int len;
		logic [2:0] c;
		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					c   = 3'($urandom_range(OP_INC, OP_BACK));
					len = $urandom_range(1, 6);
					repeat (len) issue(c, rand_value(), rand_last());
				end
				4, 5: begin
					issue(OP_JZ, rand_value(), rand_last());
					issue(OP_DEC, rand_value(), rand_last());
					issue(OP_JNZ, rand_value(), rand_last());
				end
				6: begin
					issue(OP_JZ, rand_value(), rand_last());
					issue(OP_DEC, rand_value(), rand_last());
					issue(3'($urandom_range(0, 7)), rand_value(), rand_last());
				end
				7: begin
					issue(OP_JZ, rand_value(), rand_last());
					issue(3'($urandom_range(0, 7)), rand_value(), rand_last());
				end
				default: issue(3'($urandom_range(0, 7)), rand_value(), rand_last());
			endcase
		end
		// close the final program
		issue(3'($urandom_range(0, 7)), rand_value(), 1'b1);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_ops();
		random_ops();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
